### sv/sqh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqh_pkg
// shared constants, codes and helpers of the sync quality histogram collector
// ----------------------------------------------------------------------------
package sqh_pkg;

	localparam int OFFSET_BINS   = 64;
	localparam int ENERGY_BINS   = 7;
	localparam int RATIO_CLASSES = 5;
	localparam int COUNT_WIDTH   = 32;

	localparam int OFF_W     = $clog2(OFFSET_BINS);
	localparam int OFF_MIN_W = $clog2(OFFSET_BINS + 1);
	localparam int EBIN_W    = $clog2(ENERGY_BINS);
	localparam int RBIN_W    = $clog2(RATIO_CLASSES);

	// histogram memory layout
	localparam int EN_ADDR_BASE    = OFFSET_BINS;
	localparam int RATIO_ADDR_BASE = OFFSET_BINS + ENERGY_BINS;
	localparam int MEM_DEPTH       = OFFSET_BINS + ENERGY_BINS + RATIO_CLASSES;
	localparam int MEM_AW          = $clog2(MEM_DEPTH);

	// request actions
	localparam logic [1:0] ACT_RECORD = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// read indexes
	localparam logic [6:0] IDX_TOTAL        = 7'd0;
	localparam logic [6:0] IDX_PASS         = 7'd1;
	localparam logic [6:0] IDX_FAIL         = 7'd2;
	localparam logic [6:0] IDX_OFF_MIN      = 7'd3;
	localparam logic [6:0] IDX_OFF_MAX      = 7'd4;
	localparam logic [6:0] IDX_OFF_TOTAL    = 7'd5;
	localparam logic [6:0] IDX_EN_MAX       = 7'd6;
	localparam logic [6:0] IDX_EN_MIN       = 7'd7;
	localparam logic [6:0] IDX_EN_TOTAL     = 7'd8;
	localparam int         OFF_IDX_BASE     = 16;
	localparam int         EN_IDX_BASE      = 80;
	localparam int         RATIO_IDX_BASE   = 88;

	localparam int DECADES      = 6;
	localparam int RATIO_LIMITS = 4;

	function automatic logic signed [63:0] decade_limit(input logic [2:0] k);
		logic signed [63:0] v;
		case (k)
			3'd0:    v = 64'sd1000;
			3'd1:    v = 64'sd10000;
			3'd2:    v = 64'sd100000;
			3'd3:    v = 64'sd1000000;
			3'd4:    v = 64'sd10000000;
			default: v = 64'sd100000000;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] ratio_limit(input logic [1:0] k);
		logic [7:0] v;
		case (k)
			2'd0:    v = 8'd26;
			2'd1:    v = 8'd64;
			2'd2:    v = 8'd128;
			default: v = 8'd192;
		endcase
		return v;
	endfunction

	// shift-add product of a non-negative value and a small constant
	function automatic logic [71:0] mul_small(input logic [62:0] x, input logic [7:0] k);
		logic [71:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (k[i])
				acc = acc + (72'(x) << i);
		end
		return acc;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + COUNT_WIDTH'(1);
	endfunction

endpackage
`default_nettype wire

### sv/sqh_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqh_req_if / sqh_rsp_if
// request and response channels of the sync quality histogram collector
// ----------------------------------------------------------------------------
interface sqh_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [7:0]  best_offset;
	logic signed [63:0] best_energy;
	logic signed [63:0] second_energy;
	logic               scan_passed;
	logic [6:0]         read_index;

	modport source (
		output valid, action, best_offset, best_energy, second_energy, scan_passed,
			read_index,
		input ready
	);
	modport sink (
		input valid, action, best_offset, best_energy, second_energy, scan_passed,
			read_index,
		output ready
	);
endinterface

interface sqh_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] read_value;

	modport source (output valid, read_value, input ready);
	modport sink (input valid, read_value, output ready);
endinterface
`default_nettype wire

### sv/sync_quality_histogram_collector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_quality_histogram_collector
// preamble sync scan statistics with histograms held in one synchronous memory
// ----------------------------------------------------------------------------
// One request at a time. On a failed scan a record request only bumps the
// counters; on a passed one it goes on through the rank state and a
// read-modify-write of every histogram bin it touches, through the single
// port of the histogram memory. A read request waits for the previous
// response to be taken. A clear request is done on acceptance; bins carry
// valid flags, so no sweep of the memory is needed after reset or clear.
// ----------------------------------------------------------------------------
module sync_quality_histogram_collector import sqh_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	sqh_req_if.sink     req,
	sqh_rsp_if.source   rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_RANK,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_READ
	} state_t;

	state_t state_q;

	logic signed [7:0]  off_q;
	logic signed [63:0] best_q;
	logic signed [63:0] second_q;
	logic               passed_q;
	logic [6:0]         idx_q;
	logic               rd_is_bin_q;

	logic [COUNT_WIDTH-1:0] total_q, pass_q, fail_q;
	logic [OFF_MIN_W-1:0]   off_min_q;
	logic [OFF_W-1:0]       off_max_q;
	logic [63:0]            off_sum_q;
	logic signed [63:0]     en_max_q, en_min_q, en_sum_q;

	logic [EBIN_W-1:0] en_bin_q;
	logic [71:0]       prod_sec_q;
	logic [71:0]       prod_best_q [RATIO_LIMITS];
	logic              ratio_zero_q;
	logic              off_ok_q;
	logic [MEM_AW-1:0] off_addr_q, en_addr_q, ratio_addr_q;
	logic [1:0]        step_q;

	logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]   valid_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic                   rd_valid_q;

	logic               rsp_valid_q;
	logic signed [63:0] rsp_value_q;

	logic                   req_fire;
	logic                   rq_bin;
	logic [MEM_AW-1:0]      rq_addr;
	logic                   mem_rd_en;
	logic [MEM_AW-1:0]      mem_rd_addr;
	logic                   mem_wr_en;
	logic [MEM_AW-1:0]      step_addr;
	logic [COUNT_WIDTH-1:0] bin_cur;
	logic [63:0]            scalar_val;
	logic                   off_ok;
	logic [7:0]             off_u;
	logic [OFF_W-1:0]       off_idx;
	logic [64:0]            off_sum_nx;
	logic signed [64:0]     en_sum_nx;
	logic [EBIN_W-1:0]      en_bin;
	logic [RBIN_W-1:0]      ratio_bin;
	int                     ri;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;

	// read index decode
	always_comb begin
		ri      = int'(req.read_index);
		rq_bin  = 1'b0;
		rq_addr = '0;
		if (ri >= OFF_IDX_BASE && ri < OFF_IDX_BASE + OFFSET_BINS && ri < EN_IDX_BASE) begin
			rq_bin  = 1'b1;
			rq_addr = MEM_AW'(ri - OFF_IDX_BASE);
		end else if (ri >= EN_IDX_BASE && ri < EN_IDX_BASE + ENERGY_BINS) begin
			rq_bin  = 1'b1;
			rq_addr = MEM_AW'(ri - EN_IDX_BASE + EN_ADDR_BASE);
		end else if (ri >= RATIO_IDX_BASE && ri < RATIO_IDX_BASE + RATIO_CLASSES) begin
			rq_bin  = 1'b1;
			rq_addr = MEM_AW'(ri - RATIO_IDX_BASE + RATIO_ADDR_BASE);
		end
	end

	always_comb begin
		case (idx_q)
			IDX_TOTAL:     scalar_val = 64'(total_q);
			IDX_PASS:      scalar_val = 64'(pass_q);
			IDX_FAIL:      scalar_val = 64'(fail_q);
			IDX_OFF_MIN:   scalar_val = 64'(off_min_q);
			IDX_OFF_MAX:   scalar_val = 64'(off_max_q);
			IDX_OFF_TOTAL: scalar_val = off_sum_q;
			IDX_EN_MAX:    scalar_val = en_max_q;
			IDX_EN_MIN:    scalar_val = en_min_q;
			IDX_EN_TOTAL:  scalar_val = en_sum_q;
			default:       scalar_val = '0;
		endcase
	end

	always_comb begin
		case (step_q)
			2'd0:    step_addr = off_addr_q;
			2'd1:    step_addr = en_addr_q;
			default: step_addr = ratio_addr_q;
		endcase
	end

	assign mem_rd_en   = (req_fire && req.action == ACT_READ && rq_bin) || (state_q == ST_RMW_RD);
	assign mem_rd_addr = (state_q == ST_IDLE) ? rq_addr : step_addr;
	assign mem_wr_en   = (state_q == ST_RMW_WR);
	assign bin_cur     = rd_valid_q ? rd_data_q : '0;

	// scan classification
	assign off_u      = off_q;
	assign off_ok     = (off_q >= 8'sd0) && (int'(off_q) < OFFSET_BINS);
	assign off_idx    = OFF_W'(off_u);
	assign off_sum_nx = {1'b0, off_sum_q} + 65'(off_u);
	assign en_sum_nx  = {en_sum_q[63], en_sum_q} + {best_q[63], best_q};

	always_comb begin
		en_bin = '0;
		for (int k = 0; k < DECADES; k++) begin
			if (best_q >= decade_limit(3'(k)))
				en_bin = en_bin + EBIN_W'(1);
		end
	end

	always_comb begin
		ratio_bin = '0;
		for (int k = 0; k < RATIO_LIMITS; k++) begin
			if (prod_sec_q >= prod_best_q[k])
				ratio_bin = ratio_bin + RBIN_W'(1);
		end
		if (ratio_zero_q)
			ratio_bin = '0;
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en)
			mem[step_addr] <= bump(bin_cur);
		if (mem_rd_en)
			rd_data_q <= mem[mem_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			off_q        <= '0;
			best_q       <= '0;
			second_q     <= '0;
			passed_q     <= 1'b0;
			idx_q        <= '0;
			rd_is_bin_q  <= 1'b0;
			total_q      <= '0;
			pass_q       <= '0;
			fail_q       <= '0;
			off_min_q    <= OFF_MIN_W'(OFFSET_BINS);
			off_max_q    <= '0;
			off_sum_q    <= '0;
			en_max_q     <= '0;
			en_min_q     <= {1'b0, {63{1'b1}}};
			en_sum_q     <= '0;
			en_bin_q     <= '0;
			prod_sec_q   <= '0;
			for (int k = 0; k < RATIO_LIMITS; k++)
				prod_best_q[k] <= '0;
			ratio_zero_q <= 1'b0;
			off_ok_q     <= 1'b0;
			off_addr_q   <= '0;
			en_addr_q    <= '0;
			ratio_addr_q <= '0;
			step_q       <= '0;
			valid_q      <= '0;
			rd_valid_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_value_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_READ)
				rsp_valid_q <= 1'b0;
			if (mem_rd_en)
				rd_valid_q <= valid_q[mem_rd_addr];

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						off_q       <= req.best_offset;
						best_q      <= req.best_energy;
						second_q    <= req.second_energy;
						passed_q    <= req.scan_passed;
						idx_q       <= req.read_index;
						rd_is_bin_q <= rq_bin;
						case (req.action)
							ACT_RECORD: state_q <= ST_CLASS;
							ACT_READ:   state_q <= ST_READ;
							ACT_CLEAR: begin
								total_q   <= '0;
								pass_q    <= '0;
								fail_q    <= '0;
								off_min_q <= OFF_MIN_W'(OFFSET_BINS);
								off_max_q <= '0;
								off_sum_q <= '0;
								en_max_q  <= '0;
								en_min_q  <= {1'b0, {63{1'b1}}};
								en_sum_q  <= '0;
								valid_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_CLASS: begin
					total_q <= bump(total_q);
					if (!passed_q) begin
						fail_q  <= bump(fail_q);
						state_q <= ST_IDLE;
					end else begin
						pass_q <= bump(pass_q);
						if (off_ok) begin
							off_sum_q <= off_sum_nx[64] ? {64{1'b1}} : off_sum_nx[63:0];
							if (OFF_MIN_W'(off_idx) < off_min_q)
								off_min_q <= OFF_MIN_W'(off_idx);
							if (off_idx > off_max_q)
								off_max_q <= off_idx;
						end
						if (best_q > en_max_q)
							en_max_q <= best_q;
						if (best_q < en_min_q)
							en_min_q <= best_q;
						if (en_sum_nx[64] != en_sum_nx[63])
							en_sum_q <= en_sum_nx[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
						else
							en_sum_q <= en_sum_nx[63:0];
						off_ok_q     <= off_ok;
						off_addr_q   <= MEM_AW'(off_idx);
						en_bin_q     <= en_bin;
						ratio_zero_q <= (best_q <= 64'sd0) || second_q[63];
						prod_sec_q   <= {1'b0, second_q[62:0], 8'd0};
						for (int k = 0; k < RATIO_LIMITS; k++)
							prod_best_q[k] <= mul_small(best_q[62:0], ratio_limit(2'(k)));
						state_q <= ST_RANK;
					end
				end
				ST_RANK: begin
					en_addr_q    <= MEM_AW'(EN_ADDR_BASE) + MEM_AW'(en_bin_q);
					ratio_addr_q <= MEM_AW'(RATIO_ADDR_BASE) + MEM_AW'(ratio_bin);
					step_q       <= off_ok_q ? 2'd0 : 2'd1;
					state_q      <= ST_RMW_RD;
				end
				ST_RMW_RD: begin
					state_q <= ST_RMW_WR;
				end
				ST_RMW_WR: begin
					valid_q[step_addr] <= 1'b1;
					if (step_q == 2'd2) begin
						state_q <= ST_IDLE;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= ST_RMW_RD;
					end
				end
				ST_READ: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_value_q <= rd_is_bin_q ? 64'(bin_cur) : scalar_val;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/sqh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqh_checker
// port-level checks of the sync quality histogram collector
// ----------------------------------------------------------------------------
module sqh_checker import sqh_pkg::*; (
	input wire               clk,
	input wire               arst_n,
	input wire               req_valid,
	input wire               req_ready,
	input wire [1:0]         req_action,
	input wire               req_scan_passed,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input wire signed [63:0] rsp_read_value
);

	logic req_fire;
	assign req_fire = req_valid && req_ready;

	// response holds until taken
	ast_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
		else $error("response dropped or changed while stalled");

	// after a clear the collector is ready again in the next cycle
	ast_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_action == ACT_CLEAR |=> req_ready)
		else $error("clear request did not complete in one cycle");

	// a failed scan record holds ready low only through its classify state
	ast_fail_short: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_action == ACT_RECORD && !req_scan_passed |=> !req_ready ##1 req_ready)
		else $error("failed scan record took the wrong number of cycles");

	// a response is raised only while a read is in flight
	ast_rsp_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response raised with no read in flight");

endmodule

bind sync_quality_histogram_collector sqh_checker u_sqh_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_action      (req.action),
	.req_scan_passed (req.scan_passed),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value)
);
`default_nettype wire

### sim/sqh_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqh_stats_checker
// watches the request and response channels, keeps its own copy of the scan
// statistics, and compares every read response against the value it predicts
// ----------------------------------------------------------------------------
module sqh_stats_checker import sqh_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	sqh_req_if   req,
	sqh_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	logic [COUNT_WIDTH-1:0] scans_total, scans_passed, scans_failed;
	logic [COUNT_WIDTH-1:0] off_hist [OFFSET_BINS];
	logic [COUNT_WIDTH-1:0] en_hist [ENERGY_BINS];
	logic [COUNT_WIDTH-1:0] ratio_hist [RATIO_CLASSES];
	logic [OFF_MIN_W-1:0]   off_lo;
	logic [OFF_W-1:0]       off_hi;
	logic [63:0]            off_sum;
	logic signed [63:0]     en_hi, en_lo, en_sum;
	logic signed [63:0]     read_values [$];
	logic signed [63:0]     want;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		if (&c)
			return c;
		return c + 1'b1;
	endfunction

	function automatic int decade_of(input logic signed [63:0] e);
		if (e < 64'sd1000)
			return 0;
		if (e < 64'sd10000)
			return 1;
		if (e < 64'sd100000)
			return 2;
		if (e < 64'sd1000000)
			return 3;
		if (e < 64'sd10000000)
			return 4;
		if (e < 64'sd100000000)
			return 5;
		return 6;
	endfunction

	// second/best against q8 thresholds, cross-multiplied at 72 bits
	function automatic int ratio_class(input logic signed [63:0] sec, input logic signed [63:0] best);
		logic [71:0] lhs;
		logic [71:0] b72;
		if (best <= 0 || sec < 0)
			return 0;
		lhs = {8'd0, sec} << 8;
		b72 = {8'd0, best};
		if (lhs < b72 * 72'd26)
			return 0;
		if (lhs < b72 * 72'd64)
			return 1;
		if (lhs < b72 * 72'd128)
			return 2;
		if (lhs < b72 * 72'd192)
			return 3;
		return 4;
	endfunction

	task automatic clear_stats();
		scans_total  = '0;
		scans_passed = '0;
		scans_failed = '0;
		for (int i = 0; i < OFFSET_BINS; i++)
			off_hist[i] = '0;
		for (int i = 0; i < ENERGY_BINS; i++)
			en_hist[i] = '0;
		for (int i = 0; i < RATIO_CLASSES; i++)
			ratio_hist[i] = '0;
		off_lo  = OFF_MIN_W'(OFFSET_BINS);
		off_hi  = '0;
		off_sum = '0;
		en_hi   = '0;
		en_lo   = 64'sh7fff_ffff_ffff_ffff;
		en_sum  = '0;
	endtask

	task automatic log_scan(input logic signed [7:0] off, input logic signed [63:0] be,
			input logic signed [63:0] se, input logic passed);
		logic [64:0] osum;
		logic [64:0] esum;
		int eb;
		int rb;
		scans_total = sat_inc(scans_total);
		if (!passed) begin
			scans_failed = sat_inc(scans_failed);
			return;
		end
		scans_passed = sat_inc(scans_passed);
		if (off >= 0 && off < OFFSET_BINS) begin
			off_hist[off[OFF_W-1:0]] = sat_inc(off_hist[off[OFF_W-1:0]]);
			osum = {1'b0, off_sum} + 65'(off[OFF_W-1:0]);
			off_sum = osum[64] ? '1 : osum[63:0];
			if ({1'b0, off[OFF_W-1:0]} < off_lo)
				off_lo = {1'b0, off[OFF_W-1:0]};
			if (off[OFF_W-1:0] > off_hi)
				off_hi = off[OFF_W-1:0];
		end
		eb = decade_of(be);
		rb = ratio_class(se, be);
		en_hist[eb] = sat_inc(en_hist[eb]);
		ratio_hist[rb] = sat_inc(ratio_hist[rb]);
		if (be > en_hi)
			en_hi = be;
		if (be < en_lo)
			en_lo = be;
		esum = {en_sum[63], en_sum} + {be[63], be};
		if (esum[64] != esum[63])
			en_sum = esum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
		else
			en_sum = esum[63:0];
	endtask

	function automatic logic signed [63:0] stat_value(input logic [6:0] idx);
		case (idx)
			IDX_TOTAL:     return 64'(scans_total);
			IDX_PASS:      return 64'(scans_passed);
			IDX_FAIL:      return 64'(scans_failed);
			IDX_OFF_MIN:   return 64'(off_lo);
			IDX_OFF_MAX:   return 64'(off_hi);
			IDX_OFF_TOTAL: return off_sum;
			IDX_EN_MAX:    return en_hi;
			IDX_EN_MIN:    return en_lo;
			IDX_EN_TOTAL:  return en_sum;
			default: begin
				if (idx >= OFF_IDX_BASE && idx < OFF_IDX_BASE + OFFSET_BINS)
					return 64'(off_hist[idx - OFF_IDX_BASE]);
				if (idx >= EN_IDX_BASE && idx < EN_IDX_BASE + ENERGY_BINS)
					return 64'(en_hist[idx - EN_IDX_BASE]);
				if (idx >= RATIO_IDX_BASE && idx < RATIO_IDX_BASE + RATIO_CLASSES)
					return 64'(ratio_hist[idx - RATIO_IDX_BASE]);
				return '0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stats();
			read_values.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (read_values.size() == 0) begin
					errors++;
					$display("%0t: unexpected response, expected none, got %h", $time,
						rsp.read_value);
				end else begin
					want = read_values.pop_front();
					if (rsp.read_value !== want) begin
						errors++;
						$display("%0t: read_value mismatch, expected %h, got %h", $time,
							want, rsp.read_value);
					end
				end
			end
			if (req.valid && req.ready) begin
				case (req.action)
					ACT_RECORD: log_scan(req.best_offset, req.best_energy, req.second_energy,
						req.scan_passed);
					ACT_READ:   read_values.push_back(stat_value(req.read_index));
					ACT_CLEAR:  clear_stats();
					default: ;
				endcase
			end
			pending = read_values.size();
		end
	end

endmodule

### sim/tb_sync_quality_histogram_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_quality_histogram_collector
// drives record, read, clear and ignored requests with random idle bursts on
// both channels; a separate checker predicts and compares every response
// ----------------------------------------------------------------------------
module tb_sync_quality_histogram_collector import sqh_pkg::*;;

	localparam logic [1:0]         ACT_IGNORED = 2'd3;
	localparam logic signed [63:0] E_MAX       = 64'sh7fff_ffff_ffff_ffff;
	localparam logic signed [63:0] E_MIN       = 64'sh8000_0000_0000_0000;
	localparam int                 RANDOM_REQS = 1750;
	localparam int                 QUIET_FROM  = 1520;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	bit   quiet;
	int   pick;

	sqh_req_if req ();
	sqh_rsp_if rsp ();

	sync_quality_histogram_collector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sqh_stats_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always #5 clk = ~clk;

	task automatic send(input logic [1:0] act, input logic signed [7:0] off,
			input logic signed [63:0] be, input logic signed [63:0] se, input logic passed,
			input logic [6:0] idx);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req.valid         = 1'b1;
		req.action        = act;
		req.best_offset   = off;
		req.best_energy   = be;
		req.second_energy = se;
		req.scan_passed   = passed;
		req.read_index    = idx;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic scan(input logic signed [7:0] off, input logic signed [63:0] be,
			input logic signed [63:0] se, input logic passed);
		send(ACT_RECORD, off, be, se, passed, 7'($urandom));
	endtask

	task automatic read_stat(input logic [6:0] idx);
		send(ACT_READ, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
			1'($urandom), idx);
	endtask

	task automatic random_scan();
		logic signed [7:0]  off;
		logic signed [63:0] be;
		logic signed [63:0] se;
		logic [63:0]        q8;
		if ($urandom_range(0, 9) == 0)
			off = 8'($urandom);
		else
			off = 8'($urandom_range(0, OFFSET_BINS - 1));
		case ($urandom_range(0, 9))
			0:       be = {$urandom, $urandom};
			1:       be = 64'sd0 - 64'($urandom_range(1, 5000000));
			2:       be = $urandom_range(0, 1) ? E_MAX : E_MIN;
			3, 4:    be = 64'(10 ** $urandom_range(3, 8)) + 64'($urandom_range(0, 2)) - 64'sd1;
			default: be = 64'($urandom_range(0, 10 ** $urandom_range(3, 9)));
		endcase
		case ($urandom_range(0, 3))
			0: q8 = 64'd26;
			1: q8 = 64'd64;
			2: q8 = 64'd128;
			default: q8 = 64'd192;
		endcase
		case ($urandom_range(0, 7))
			0:       se = {$urandom, $urandom};
			1:       se = 64'sd0 - 64'($urandom_range(1, 1000));
			2, 3:    se = (be >>> 8) * $signed(q8) + 64'($urandom_range(0, 2)) - 64'sd1;
			default: se = (be * 64'($urandom_range(0, 300))) >>> 8;
		endcase
		scan(off, be, se, $urandom_range(0, 6) != 0);
	endtask

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			rsp.ready = 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		quiet             = 1'b0;
		req.valid         = 1'b0;
		req.action        = ACT_RECORD;
		req.best_offset   = '0;
		req.best_energy   = '0;
		req.second_energy = '0;
		req.scan_passed   = 1'b0;
		req.read_index    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		read_stat(IDX_EN_MIN);
		read_stat(IDX_OFF_MIN);
		scan(8'sd0, 64'sd999, 64'sd0, 1'b1);
		scan(8'sd63, 64'sd1000, 64'sd101, 1'b1);
		scan(8'sd64, 64'sd99999999, 64'sd99999999, 1'b1);
		scan(-8'sd1, 64'sd100000000, 64'sd1, 1'b1);
		scan(8'sd127, E_MAX, E_MAX, 1'b1);
		scan(8'sd5, E_MAX, 64'sd1, 1'b1);
		scan(8'sd7, 64'sd0, 64'sd100, 1'b1);
		scan(8'sd9, 64'sd500, -64'sd3, 1'b1);
		scan(8'sd10, 64'sd256, 64'sd26, 1'b1);
		scan(8'sd11, 64'sd256, 64'sd64, 1'b1);
		scan(8'sd12, 64'sd256, 64'sd127, 1'b1);
		scan(8'sd13, 64'sd256, 64'sd192, 1'b1);
		scan(8'sd20, 64'sd12345, 64'sd999, 1'b0);
		send(ACT_IGNORED, 8'sd3, 64'sd5000, 64'sd10, 1'b1, IDX_TOTAL);
		repeat (3) scan(-8'sd128, E_MIN, 64'sd5, 1'b1);
		read_stat(IDX_EN_TOTAL);
		read_stat(IDX_EN_MAX);
		read_stat(IDX_OFF_TOTAL);
		read_stat(7'd127);
		read_stat(7'd87);
		send(ACT_CLEAR, 8'sd0, 64'sd0, 64'sd0, 1'b0, IDX_TOTAL);
		read_stat(IDX_OFF_MIN);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 150 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (n >= QUIET_FROM)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 55)
				random_scan();
			else if (pick < 62)
				read_stat(7'($urandom_range(0, 8)));
			else if (pick < 92)
				read_stat(7'($urandom));
			else if (pick < 94)
				send(ACT_CLEAR, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
					1'($urandom), 7'($urandom));
			else if (pick < 96)
				send(ACT_IGNORED, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
					1'($urandom), 7'($urandom));
			else
				scan(8'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		end
		for (int i = 0; i < 128; i++)
			read_stat(7'(i));

		@(negedge clk);
		req.valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
